// File: src/shelf_atlas_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// shelf_atlas_allocator_core_defines
// Assertion macros used by the shelf atlas allocator datapath.
// ----------------------------------------------------------------------------
`ifndef SHELF_ATLAS_ALLOCATOR_CORE_DEFINES_SVH
`define SHELF_ATLAS_ALLOCATOR_CORE_DEFINES_SVH

// consequence must hold in the same cycle as the antecedent
`define SAA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence must hold in the cycle after the antecedent
`define SAA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/saa_pkg.sv
// ----------------------------------------------------------------------------
// saa_pkg
// Types, codes and helper functions of the shelf atlas allocator.
// ----------------------------------------------------------------------------
package saa_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_START_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXACT_MODE   = 3'd4;

	// reset sizes of the atlas
	localparam logic [14:0] RST_START_SIZE = 15'd256;
	localparam logic [14:0] RST_LIMIT_SIZE = 15'd4096;

	// kind of result written by the emit command
	localparam logic [1:0] RES_PLACE  = 2'd0;
	localparam logic [1:0] RES_OPEN   = 2'd1;
	localparam logic [1:0] RES_FAIL   = 2'd2;
	localparam logic [1:0] RES_FINISH = 2'd3;

	// one row (shelf) of the row table
	typedef struct packed {
		logic [14:0] top;
		logic [14:0] tall;
		logic [15:0] used;
	} row_entry_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       scan_step;
		logic       grow;
		logic       emit;
		logic [1:0] kind;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic finish;
		logic scan_end;
		logic found;
		logic rows_full;
		logic height_fits;
		logic at_limit;
		logic out_free;
	} sts_t;

	// double a size (zero grows to one), clamped to its limit
	function automatic logic [14:0] grow_size(input logic [14:0] size,
		input logic [14:0] limit);
		logic [15:0] d;
		d = (size == '0) ? 16'd1 : {size, 1'b0};
		return (d < {1'b0, limit}) ? d[14:0] : limit;
	endfunction

	// smallest power of two at or above v, saturating at 15 bits, zero for zero
	function automatic logic [14:0] pow2_ceil(input logic [15:0] v);
		logic [14:0] p;
		p = 15'h7FFF;
		for (int k = 14; k >= 0; k--) begin
			if ((16'd1 << k) >= v) begin
				p = 15'(16'd1 << k);
			end
		end
		if (v == '0) begin
			p = '0;
		end
		return p;
	endfunction

endpackage

// File: src/saa_ctrl.sv
// ----------------------------------------------------------------------------
// saa_ctrl
// Sequencer of the shelf atlas allocator: accept, scan, grow, emit.
// ----------------------------------------------------------------------------
module saa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  saa_pkg::sts_t sts,
	output saa_pkg::cmd_t cmd
);
	import saa_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_START  = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_GROW   = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] kind_q, kind_d;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		kind_d        = kind_q;
		cmd           = '0;
		cmd.kind      = kind_q;
		in_ready      = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (sts.finish) begin
					kind_d  = RES_FINISH;
					state_d = S_EMIT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_end) begin
					state_d = S_DECIDE;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_DECIDE: begin
				if (sts.found) begin
					kind_d  = RES_PLACE;
					state_d = S_EMIT;
				end else if (sts.rows_full) begin
					kind_d  = RES_FAIL;
					state_d = S_EMIT;
				end else begin
					state_d = S_GROW;
				end
			end
			S_GROW: begin
				if (sts.height_fits) begin
					kind_d  = RES_OPEN;
					state_d = S_EMIT;
				end else if (sts.at_limit) begin
					kind_d  = RES_FAIL;
					state_d = S_EMIT;
				end else begin
					cmd.grow = 1'b1;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= RES_FAIL;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

endmodule

// File: src/saa_datapath.sv
// ----------------------------------------------------------------------------
// saa_datapath
// Row table, atlas size registers, best-fit scan and result register.
// ----------------------------------------------------------------------------
`include "shelf_atlas_allocator_core_defines.svh"

module saa_datapath #(
	parameter int MAX_ROWS = 64,
	parameter int PAD      = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [saa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [saa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           mode,
	input  logic [13:0]                    rect_width,
	input  logic [13:0]                    rect_height,
	input  saa_pkg::cmd_t                  cmd,
	output saa_pkg::sts_t                  sts,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           placed,
	output logic [14:0]                    left_x,
	output logic [14:0]                    top_y,
	output logic [14:0]                    right_x,
	output logic [14:0]                    bottom_y,
	output logic [14:0]                    atlas_width,
	output logic [14:0]                    atlas_height
);
	import saa_pkg::*;

	localparam int AW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_ROWS + 1);

	// configuration and atlas state
	logic [14:0]   limit_width_q, limit_height_q;
	logic          exact_q;
	logic [CW-1:0] row_count_q;
	logic [15:0]   next_top_q;
	logic [14:0]   cur_width_q, cur_height_q;

	// current item
	logic          mode_q;
	logic [13:0]   rw_q, rh_q;
	logic [14:0]   gw, gh;

	// scan
	logic [CW-1:0] scan_idx_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	row_entry_t    rd_data_s1;
	logic          best_vld_q;
	logic [AW-1:0] best_idx_q;
	logic [14:0]   best_top_q, best_tall_q;
	logic [15:0]   best_used_q;
	logic [16:0]   fit_sum, need;
	logic          row_fit, row_better;

	// row table
	row_entry_t    row_mem [MAX_ROWS];
	logic          mem_we;
	logic [AW-1:0] wr_addr;
	row_entry_t    wr_entry;

	// result
	logic          out_valid_q;
	logic          res_placed;
	logic [14:0]   res_x, res_y, res_h, p2;
	logic          empty;

	assign gw = 15'(rw_q) + 15'(PAD);
	assign gh = 15'(rh_q) + 15'(PAD);

	// row compare against the best so far
	assign fit_sum    = 17'(rd_data_s1.used) + 17'(gw);
	assign row_fit    = (fit_sum <= 17'(cur_width_q)) && (gh <= rd_data_s1.tall);
	assign row_better = !best_vld_q || (rd_data_s1.tall < best_tall_q) ||
		((rd_data_s1.tall == best_tall_q) && (rd_data_s1.used < best_used_q));

	assign need  = 17'(next_top_q) + 17'(gh);
	assign empty = (row_count_q == '0) && (next_top_q == '0);
	assign p2    = pow2_ceil(next_top_q);

	// status to the controller
	always_comb begin
		sts.finish      = mode_q;
		sts.scan_end    = (scan_idx_q == row_count_q);
		sts.found       = best_vld_q;
		sts.rows_full   = (row_count_q >= CW'(MAX_ROWS));
		sts.height_fits = (17'(cur_height_q) >= need);
		sts.at_limit    = (cur_width_q >= limit_width_q) && (cur_height_q >= limit_height_q);
		sts.out_free    = !out_valid_q || out_ready;
	end

	// result fields and row table write for each result kind
	always_comb begin
		mem_we     = 1'b0;
		wr_addr    = best_idx_q;
		wr_entry   = '{top: best_top_q, tall: best_tall_q, used: best_used_q + 16'(gw)};
		res_placed = 1'b0;
		res_x      = '0;
		res_y      = '0;
		res_h      = cur_height_q;
		case (cmd.kind)
			RES_PLACE: begin
				mem_we     = cmd.emit;
				res_placed = 1'b1;
				res_x      = best_used_q[14:0];
				res_y      = best_top_q;
			end
			RES_OPEN: begin
				mem_we     = cmd.emit;
				wr_addr    = row_count_q[AW-1:0];
				wr_entry   = '{top: next_top_q[14:0], tall: gh, used: 16'(gw)};
				res_placed = 1'b1;
				res_y      = next_top_q[14:0];
			end
			RES_FINISH: begin
				res_h = exact_q ? next_top_q[14:0] : p2;
			end
			default: begin
				res_placed = 1'b0;
			end
		endcase
	end

	// row table memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_mem[wr_addr] <= wr_entry;
		end
		if (cmd.scan_step) begin
			rd_data_s1 <= row_mem[scan_idx_q[AW-1:0]];
		end
	end

	// control and atlas state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_width_q  <= RST_LIMIT_SIZE;
			limit_height_q <= RST_LIMIT_SIZE;
			exact_q        <= 1'b0;
			row_count_q    <= '0;
			next_top_q     <= '0;
			cur_width_q    <= RST_START_SIZE;
			cur_height_q   <= RST_START_SIZE;
			scan_idx_q     <= '0;
			rd_vld_s1      <= 1'b0;
			best_vld_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			// a start size only matters while the atlas is still empty
			if (cfg_we) begin
				case (cfg_index)
					REG_START_WIDTH: begin
						if (empty) cur_width_q <= cfg_data;
					end
					REG_START_HEIGHT: begin
						if (empty) cur_height_q <= cfg_data;
					end
					REG_LIMIT_WIDTH:  limit_width_q  <= cfg_data;
					REG_LIMIT_HEIGHT: limit_height_q <= cfg_data;
					REG_EXACT_MODE:   exact_q        <= cfg_data[0];
					default: begin
						exact_q <= exact_q;
					end
				endcase
			end

			// scan sequencing
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.load) begin
				scan_idx_q <= '0;
				best_vld_q <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + CW'(1);
			end
			if (rd_vld_s1 && row_fit && row_better) begin
				best_vld_q <= 1'b1;
			end

			// atlas growth
			if (cmd.grow) begin
				cur_width_q  <= grow_size(cur_width_q, limit_width_q);
				cur_height_q <= grow_size(cur_height_q, limit_height_q);
			end

			// commit of the result
			if (cmd.emit) begin
				if (cmd.kind == RES_OPEN) begin
					row_count_q <= row_count_q + CW'(1);
					next_top_q  <= next_top_q + 16'(gh);
				end
				if (cmd.kind == RES_FINISH) begin
					cur_height_q <= p2;
				end
			end

			// result register handshake
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item capture, best row and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			rw_q   <= rect_width;
			rh_q   <= rect_height;
		end
		if (cmd.scan_step) begin
			rd_idx_s1 <= scan_idx_q[AW-1:0];
		end
		if (rd_vld_s1 && row_fit && row_better) begin
			best_idx_q  <= rd_idx_s1;
			best_top_q  <= rd_data_s1.top;
			best_tall_q <= rd_data_s1.tall;
			best_used_q <= rd_data_s1.used;
		end
		if (cmd.emit) begin
			placed       <= res_placed;
			left_x       <= res_x;
			top_y        <= res_y;
			right_x      <= res_placed ? (res_x + 15'(rw_q)) : 15'd0;
			bottom_y     <= res_placed ? (res_y + 15'(rh_q)) : 15'd0;
			atlas_width  <= cur_width_q;
			atlas_height <= res_h;
		end
	end

	assign out_valid = out_valid_q;

	`SAA_ASSERT_NOW(a_emit_free, clk, arst_n, cmd.emit, !out_valid_q || out_ready, "result register overwritten")
	`SAA_ASSERT_NEXT(a_emit_valid, clk, arst_n, cmd.emit, out_valid_q, "emitted item not presented")
	`SAA_ASSERT_NOW(a_row_bound, clk, arst_n, 1'b1, row_count_q <= CW'(MAX_ROWS), "row count beyond table")
	`SAA_ASSERT_NOW(a_open_room, clk, arst_n, cmd.emit && (cmd.kind == RES_OPEN), !sts.rows_full && sts.height_fits, "row opened without room")
	`SAA_ASSERT_NEXT(a_open_count, clk, arst_n, cmd.emit && (cmd.kind == RES_OPEN), row_count_q == $past(row_count_q) + CW'(1), "row count not advanced")

endmodule

// File: src/shelf_atlas_allocator_core.sv
// ----------------------------------------------------------------------------
// shelf_atlas_allocator_core
// Shelf based rectangle packer for a texture atlas, best height fit per row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item: mode 0 places a
//   rectangle of rect_width x rect_height plus padding, mode 1 finishes and
//   reports the final atlas height. Every item gives exactly one result item
//   on the output channel (out_valid/out_ready).
//   A place item scans every stored row once through the row table read
//   port. When no stored row fits and the row table has room, the sequencer
//   checks the height and then doubles the atlas until the row fits or the
//   size limit is reached. A finish item skips the scan.
//   One item is in work at a time; in_ready is high while the sequencer idles,
//   even when the previous result still waits in the output register.
//   When the receiver stalls, the block holds its result and the next item
//   stops just before writing its own result.
//   Configuration (cfg_we/cfg_index/cfg_data) writes take effect at once; the
//   user must only issue them while no item is in work, unenforced by the block.
//   Reset (arst_n low) empties the row table and loads the default sizes.
// ----------------------------------------------------------------------------
module shelf_atlas_allocator_core #(
	parameter int MAX_ROWS = 64,
	parameter int PAD      = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [saa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [saa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic [13:0]                    rect_width,
	input  logic [13:0]                    rect_height,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           placed,
	output logic [14:0]                    left_x,
	output logic [14:0]                    top_y,
	output logic [14:0]                    right_x,
	output logic [14:0]                    bottom_y,
	output logic [14:0]                    atlas_width,
	output logic [14:0]                    atlas_height
);
	import saa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	saa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// row table and arithmetic
	saa_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.PAD      (PAD)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.rect_width   (rect_width),
		.rect_height  (rect_height),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.placed       (placed),
		.left_x       (left_x),
		.top_y        (top_y),
		.right_x      (right_x),
		.bottom_y     (bottom_y),
		.atlas_width  (atlas_width),
		.atlas_height (atlas_height)
	);

endmodule
